/* sv/scba_pkg.sv */
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants for the size-class buffer allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

    // Size-limit registers
    localparam int NUM_REGS    = 4;
    localparam int LIMIT_W     = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET [NUM_REGS] = '{
        16'd32, 16'd128, 16'd512, 16'd1024
    };

    // Default geometry
    localparam int DEF_NUM_CLASSES     = 4;
    localparam int DEF_SLOTS_PER_CLASS = 8;

    // Fixed field widths
    localparam int CMD_W     = 1;
    localparam int SIZE_W    = 16;
    localparam int FREE_H_W  = 6;
    localparam int GRANT_H_W = 5;
    localparam int STATUS_W  = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BUFFER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

    typedef logic [LIMIT_W-1:0] limit_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [GRANT_H_W-1:0] granted_handle;
    } result_t;

endpackage

/* sv/scba_regs.sv */
// ----------------------------------------------------------------------------
// scba_regs
// APB register file holding the per-class size limits.
// ----------------------------------------------------------------------------
module scba_regs
    import scba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output limit_t              limits [NUM_REGS]
);

    limit_t     limit_reg [NUM_REGS];
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                limit_reg[i] <= LIMIT_RESET[i];
            end
        end
        else if (wr_en)
        begin
            limit_reg[reg_idx] <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = DATA_W'(limit_reg[reg_idx]);
    assign limits = limit_reg;

endmodule

/* sv/scba_decide.sv */
// ----------------------------------------------------------------------------
// scba_decide
// Combinational decision: class fit, lowest free slot, map update.
// ----------------------------------------------------------------------------
module scba_decide
    import scba_pkg::*;
#(
    parameter int NUM_CLASSES     = DEF_NUM_CLASSES,
    parameter int SLOTS_PER_CLASS = DEF_SLOTS_PER_CLASS
)
(
    input  logic [CMD_W-1:0]                     cmd,
    input  logic [SIZE_W-1:0]                    req_size,
    input  logic [FREE_H_W-1:0]                  free_handle,
    input  limit_t                               limits [NUM_REGS],
    input  logic [NUM_CLASSES*SLOTS_PER_CLASS-1:0] map_cur,
    output logic [NUM_CLASSES*SLOTS_PER_CLASS-1:0] map_next,
    output result_t                              result
);

    localparam int TOTAL  = NUM_CLASSES * SLOTS_PER_CLASS;
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SLOT_W = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
    localparam int IDX_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    logic [NUM_CLASSES-1:0]             class_hit;
    logic [NUM_CLASSES-1:0][SLOT_W-1:0] low_slot;

    for (genvar c = 0; c < NUM_CLASSES; c++)
    begin : g_class
        limit_t                     limit;
        logic [SLOTS_PER_CLASS-1:0] free_bits;

        if (c < NUM_REGS)
        begin : g_reg
            assign limit = limits[c];
        end
        else
        begin : g_none
            assign limit = '0;
        end

        assign free_bits    = ~map_cur[c*SLOTS_PER_CLASS +: SLOTS_PER_CLASS];
        assign class_hit[c] = (limit != '0) && (req_size <= limit) && (|free_bits);

        // lowest free slot within the class
        always_comb
        begin
            low_slot[c] = '0;
            for (int s = SLOTS_PER_CLASS - 1; s >= 0; s--)
            begin
                if (free_bits[s])
                begin
                    low_slot[c] = SLOT_W'(s);
                end
            end
        end
    end

    logic [CLS_W-1:0]  cls_sel;
    logic              found;
    logic [31:0]       grant32;
    logic [31:0]       free32;
    logic [IDX_W-1:0]  grant_idx;
    logic [IDX_W-1:0]  free_idx;
    logic              handle_ok;

    always_comb
    begin
        cls_sel = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (class_hit[c])
            begin
                cls_sel = CLS_W'(c);
            end
        end
    end

    assign found     = |class_hit;
    assign grant32   = 32'(cls_sel) * 32'(SLOTS_PER_CLASS) + 32'(low_slot[cls_sel]);
    assign grant_idx = grant32[IDX_W-1:0];
    assign free32    = 32'(free_handle);
    assign free_idx  = free32[IDX_W-1:0];
    assign handle_ok = (free32 < 32'(TOTAL));

    always_comb
    begin
        map_next              = map_cur;
        result.status         = ST_OK;
        result.granted_handle = '0;
        case (cmd)
            CMD_ALLOC:
            begin
                if (found)
                begin
                    map_next[grant_idx]   = 1'b1;
                    result.granted_handle = grant32[GRANT_H_W-1:0];
                end
                else
                begin
                    result.status = ST_NO_BUFFER;
                end
            end
            CMD_FREE:
            begin
                if (handle_ok)
                begin
                    map_next[free_idx] = 1'b0;
                end
                else
                begin
                    result.status = ST_BAD_HANDLE;
                end
            end
            default:
            begin
                result.status = ST_OK;
            end
        endcase
    end

endmodule

/* sv/size_class_buffer_allocator_unit.sv */
// ----------------------------------------------------------------------------
// size_class_buffer_allocator_unit
// Size-class buffer allocator: in-use map, allocate and free requests.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless rsp_ready stalls the response, and
// returns one response per request via the request register, then the
// response register. The rate is set by the in-use map update, decided
// combinationally from the request register: class fit compare, per-class
// lowest free slot and class priority select. Each class limit register is
// at 4*class; a zero limit disables the class. The map clears at reset.
// ----------------------------------------------------------------------------
module size_class_buffer_allocator_unit
    import scba_pkg::*;
#(
    parameter int NUM_CLASSES     = DEF_NUM_CLASSES,
    parameter int SLOTS_PER_CLASS = DEF_SLOTS_PER_CLASS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,

    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [SIZE_W-1:0]     req_size,
    input  logic [FREE_H_W-1:0]   free_handle,

    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [GRANT_H_W-1:0]  granted_handle
);

    localparam int TOTAL = NUM_CLASSES * SLOTS_PER_CLASS;

    limit_t limits [NUM_REGS];

    scba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    // request stage
    logic                 req_vld_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [FREE_H_W-1:0]  handle_reg;

    // response stage
    logic                 rsp_vld_reg;
    result_t              result_reg;
    result_t              result_next;

    logic [TOTAL-1:0]     map_reg;
    logic [TOTAL-1:0]     map_next;

    logic                 rsp_adv;
    logic                 req_adv;
    logic                 req_take;

    assign rsp_adv   = !rsp_vld_reg || rsp_ready;
    assign req_adv   = req_vld_reg && rsp_adv;
    assign req_ready = !req_vld_reg || rsp_adv;
    assign req_take  = req_valid && req_ready;

    scba_decide #(
        .NUM_CLASSES     (NUM_CLASSES),
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_decide (
        .cmd         (cmd_reg),
        .req_size    (size_reg),
        .free_handle (handle_reg),
        .limits      (limits),
        .map_cur     (map_reg),
        .map_next    (map_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
            map_reg     <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                req_vld_reg <= req_valid;
            end
            if (rsp_adv)
            begin
                rsp_vld_reg <= req_vld_reg;
            end
            if (req_adv)
            begin
                map_reg <= map_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg    <= cmd;
            size_reg   <= req_size;
            handle_reg <= free_handle;
        end
        if (req_adv)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp_valid      = rsp_vld_reg;
    assign status         = result_reg.status;
    assign granted_handle = result_reg.granted_handle;

endmodule
